>>> src/nde_pkg.sv
`default_nettype none

package nde_pkg;

  localparam int unsigned PairW  = 8;
  localparam int unsigned DaysW  = 14;
  localparam int unsigned TodW   = 17;
  localparam int unsigned SecW   = 30;
  localparam int unsigned InW    = 104;
  localparam int unsigned OutW   = 32;

  localparam logic [PairW-1:0] EpochYy    = 8'd70;
  localparam logic [PairW-1:0] MaxMonth   = 8'd12;
  localparam logic [PairW-1:0] MaxDay     = 8'd31;
  localparam logic [PairW-1:0] MaxMinSec  = 8'd59;
  localparam logic [PairW-1:0] MaxHour    = 8'd24;
  localparam logic [2:0]       FieldLen   = 3'd6;
  localparam logic [16:0]      SecPerDay  = 17'd86400;

  // decoded two-digit fields
  typedef struct packed {
    logic             ok;
    logic [PairW-1:0] yy;
    logic [PairW-1:0] mon;
    logic [PairW-1:0] day;
    logic [PairW-1:0] hr;
    logic [PairW-1:0] mn;
    logic [PairW-1:0] sc;
  } dec_t;

  typedef struct packed {
    logic             ok;
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
  } days_t;

  typedef struct packed {
    logic             ok;
    logic [SecW-1:0]  prod;
    logic [TodW-1:0]  tod;
  } prod_t;

  // days from 1970-01-01 to Jan 1 of 1900+yy, zero before 1970
  function automatic logic [DaysW-1:0] year_days(input logic [PairW-1:0] yy);
    logic [PairW-1:0] span;
    logic [PairW-1:0] leaps;
    logic [23:0]      acc;
    span  = yy - EpochYy;
    leaps = ((yy - 8'd1) >> 2) - 8'd17;
    acc   = 24'(span) * 24'd365 + 24'(leaps);
    if (yy < EpochYy) begin
      return '0;
    end
    return acc[DaysW-1:0];
  endfunction

  // days in the months before the given one, non-leap year
  function automatic logic [8:0] month_days(input logic [PairW-1:0] mon);
    logic [8:0] r;
    case (mon)
      8'd1:    r = 9'd0;
      8'd2:    r = 9'd31;
      8'd3:    r = 9'd59;
      8'd4:    r = 9'd90;
      8'd5:    r = 9'd120;
      8'd6:    r = 9'd151;
      8'd7:    r = 9'd181;
      8'd8:    r = 9'd212;
      8'd9:    r = 9'd243;
      8'd10:   r = 9'd273;
      8'd11:   r = 9'd304;
      8'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/nde_decode.sv
`default_nettype none

module nde_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [47:0]        date_chars_i,
  input  wire logic [2:0]         date_len_i,
  input  wire logic [47:0]        time_chars_i,
  input  wire logic [2:0]         time_len_i,
  output logic                    valid_o,
  output nde_pkg::dec_t           dec_o
);
  import nde_pkg::*;

  logic  valid_q;
  dec_t  dec_d, dec_q;
  logic [11:0] digit_ok;
  logic [47:0] chars [2];

  assign chars[0] = date_chars_i;
  assign chars[1] = time_chars_i;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int b = 0; b < 6; b++) begin
        digit_ok[s*6+b] = (chars[s][8*b+7 -: 4] == 4'h3) && (chars[s][8*b+3 -: 4] <= 4'd9);
      end
    end
  end

  function automatic logic [PairW-1:0] pair(input logic [15:0] two);
    return PairW'(two[11:8]) * 8'd10 + PairW'(two[3:0]);
  endfunction

  always_comb begin
    dec_d.ok  = (date_len_i == FieldLen) && (time_len_i == FieldLen) && (&digit_ok);
    dec_d.yy  = pair(date_chars_i[47:32]);
    dec_d.mon = pair(date_chars_i[31:16]);
    dec_d.day = pair(date_chars_i[15:0]);
    dec_d.hr  = pair(time_chars_i[47:32]);
    dec_d.mn  = pair(time_chars_i[31:16]);
    dec_d.sc  = pair(time_chars_i[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

>>> src/nde_days.sv
`default_nettype none

module nde_days (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire nde_pkg::dec_t      dec_i,
  output logic                    valid_o,
  output nde_pkg::days_t          days_o
);
  import nde_pkg::*;

  logic        valid_q;
  days_t       days_d, days_q;
  logic        in_range;
  logic        hr_wrap;
  logic        leap_adj;
  logic [PairW-1:0] hr_eff;

  always_comb begin
    in_range = (dec_i.mon >= 8'd1) && (dec_i.mon <= MaxMonth) &&
               (dec_i.day >= 8'd1) && (dec_i.day <= MaxDay) &&
               (dec_i.mn <= MaxMinSec) && (dec_i.sc <= MaxMinSec) &&
               (dec_i.hr <= MaxHour);
    hr_wrap  = (dec_i.hr == MaxHour);
    hr_eff   = hr_wrap ? '0 : dec_i.hr;
    leap_adj = (dec_i.yy[1:0] == 2'b00) && (dec_i.mon > 8'd2);
    days_d.ok   = dec_i.ok && in_range;
    days_d.days = year_days(dec_i.yy) + DaysW'(month_days(dec_i.mon)) +
                  DaysW'(leap_adj) + DaysW'(dec_i.day) - DaysW'(1) + DaysW'(hr_wrap);
    days_d.tod  = TodW'(hr_eff) * 17'd3600 + TodW'(dec_i.mn) * 17'd60 + TodW'(dec_i.sc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_q <= days_d;
    end
  end

  assign valid_o = valid_q;
  assign days_o  = days_q;

endmodule

`default_nettype wire

>>> src/nde_scale.sv
`default_nettype none

module nde_scale (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire nde_pkg::days_t     days_i,
  output logic                    valid_o,
  output logic                    ok_o,
  output logic [nde_pkg::SecW-1:0] seconds_o
);
  import nde_pkg::*;

  logic        mul_valid_q, out_valid_q;
  prod_t       prod_d, prod_q;
  logic [30:0] full_prod;
  logic [SecW-1:0] sum_d, sum_q;
  logic        ok_q;

  // stage 3: scale days to seconds
  always_comb begin
    full_prod   = 31'(days_i.days) * 31'(SecPerDay);
    prod_d.ok   = days_i.ok;
    prod_d.prod = full_prod[SecW-1:0];
    prod_d.tod  = days_i.tod;
  end

  // stage 4: add time of day, zero a failed item
  always_comb begin
    sum_d = prod_q.prod + SecW'(prod_q.tod);
    if (!prod_q.ok) begin
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_valid_q <= valid_i;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      ok_q   <= prod_q.ok;
    end
  end

  assign valid_o   = out_valid_q;
  assign ok_o      = ok_q;
  assign seconds_o = sum_q;

endmodule

`default_nettype wire

>>> src/nntp_date_to_epoch_seconds.sv
// Converts a yymmdd date and an hhmmss time, each six ASCII digits with a
// length, to seconds since 1970-01-01 00:00 (year 1900+yy, every fourth year
// leap, hour 24 rolls into the next day). A bad length, non-digit or field out
// of range yields valid_res 0 and seconds 0. The block is a four-stage pipeline
// (digit decode, day count, multiply by 86400, add time of day and output
// register): one item per cycle unless the output stalls. All stages advance
// together whenever the output register is empty or taken, so s_axis_tready
// follows m_axis_tready while the output holds.
`default_nettype none

module nntp_date_to_epoch_seconds (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [47:0] date_chars, [50:48] date_len, [98:51] time_chars, [101:99] time_len
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] valid_res, [30:1] epoch_seconds
  output logic [31:0]       m_axis_tdata
);
  import nde_pkg::*;

  logic        en;
  logic        v1, v2, v3;
  dec_t        dec;
  days_t       days;
  logic        ok;
  logic [SecW-1:0] seconds;

  // advance the whole pipe unless a result waits unaccepted
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  nde_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .date_chars_i (s_axis_tdata[47:0]),
    .date_len_i   (s_axis_tdata[50:48]),
    .time_chars_i (s_axis_tdata[98:51]),
    .time_len_i   (s_axis_tdata[101:99]),
    .valid_o      (v1),
    .dec_o        (dec)
  );

  nde_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .dec_i   (dec),
    .valid_o (v2),
    .days_o  (days)
  );

  nde_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v2),
    .days_i    (days),
    .valid_o   (v3),
    .ok_o      (ok),
    .seconds_o (seconds)
  );

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {1'b0, seconds, ok};

  // a failed item carries zero seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !ok |-> seconds == '0)
    else $error("invalid result with nonzero seconds");

  // results never exceed 991231 245959, one hour past the end of 1999
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seconds <= 30'd946688399)
    else $error("seconds out of range");

  // an accepted item lands in the decode stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted item lost in decode stage");

  // a stalled output blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

endmodule

`default_nettype wire

>>> tb/nntp_date_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps

module nntp_date_to_epoch_seconds_tb;

  localparam int unsigned NumRandom  = 1650;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainTail  = 12;
  localparam int unsigned LongHold   = 80;

  typedef struct packed {
    logic        ok;
    logic [29:0] secs;
  } epoch_t;

  typedef struct {
    logic [47:0] dchars;
    logic [2:0]  dlen;
    logic [47:0] tchars;
    logic [2:0]  tlen;
    bit          typed;
    epoch_t      want;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [nde_pkg::InW-1:0]  s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [nde_pkg::OutW-1:0] m_axis_tdata;

  epoch_t      epoch_q[$];
  stim_row_t   stim_tab[$];
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_conv = 0;
  int unsigned n_rej = 0;
  int unsigned idle_cycles = 0;

  nntp_date_to_epoch_seconds dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected conversion of one packed input item
  function automatic epoch_t epoch_of(input logic [nde_pkg::InW-1:0] w);
    logic [47:0]  dc;
    logic [47:0]  tc;
    logic [7:0]   b;
    int unsigned  v[12];
    int unsigned  yr, mo, dy, hr, mi, se, days, y, m, total;
    epoch_t       r;
    r  = '0;
    dc = w[47:0];
    tc = w[98:51];
    if (w[50:48] != 3'd6 || w[101:99] != 3'd6) return r;
    for (int i = 0; i < 6; i++) begin
      b = dc[47-8*i -: 8];
      if (b < 8'h30 || b > 8'h39) return r;
      v[i] = 32'(b - 8'h30);
      b = tc[47-8*i -: 8];
      if (b < 8'h30 || b > 8'h39) return r;
      v[i+6] = 32'(b - 8'h30);
    end
    yr = 1900 + v[0] * 10 + v[1];
    mo = v[2] * 10 + v[3];
    dy = v[4] * 10 + v[5];
    hr = v[6] * 10 + v[7];
    mi = v[8] * 10 + v[9];
    se = v[10] * 10 + v[11];
    if (mo < 1 || mo > 12 || dy < 1 || dy > 31 || mi > 59 || se > 59 || hr > 24) return r;
    // hour 24 rolls into the next day number, unchecked against month length
    if (hr == 24) begin
      hr = 0;
      dy++;
    end
    days = 0;
    for (y = 1970; y < yr; y++) days += (y % 4 == 0) ? 366 : 365;
    if (yr % 4 == 0 && mo > 2) days++;
    for (m = 1; m < mo; m++) begin
      days += (m == 2) ? 28 : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
    end
    days += dy - 1;
    total  = ((days * 24 + hr) * 60 + mi) * 60 + se;
    r.ok   = 1'b1;
    r.secs = total[29:0];
    return r;
  endfunction

  function automatic logic [15:0] dig2(input int unsigned n);
    return {8'(8'h30 + n / 10), 8'(8'h30 + n % 10)};
  endfunction

  function automatic void add_row(input logic [47:0] d, input logic [2:0] dl,
                                  input logic [47:0] t, input logic [2:0] tl,
                                  input bit typed, input logic ok,
                                  input logic [29:0] secs);
    stim_row_t row;
    row.dchars = d;
    row.dlen   = dl;
    row.tchars = t;
    row.tlen   = tl;
    row.typed  = typed;
    row.want   = '{ok: ok, secs: secs};
    stim_tab.push_back(row);
  endfunction

  // mostly well-formed dates and times, the rest bent or noise
  function automatic logic [nde_pkg::InW-1:0] rand_word();
    logic [47:0] dc;
    logic [47:0] tc;
    logic [2:0]  dl;
    logic [2:0]  tl;
    logic [7:0]  bval;
    int unsigned kind, pos;
    kind = $urandom_range(0, 9);
    dl   = 3'd6;
    tl   = 3'd6;
    dc   = {dig2($urandom_range(0, 99)), dig2($urandom_range(1, 12)),
            dig2($urandom_range(1, 31))};
    tc   = {dig2($urandom_range(0, 24)), dig2($urandom_range(0, 59)),
            dig2($urandom_range(0, 59))};
    case (kind)
      6: begin
        dc = {dig2($urandom_range(0, 99)), dig2($urandom_range(0, 99)),
              dig2($urandom_range(0, 99))};
        tc = {dig2($urandom_range(0, 99)), dig2($urandom_range(0, 99)),
              dig2($urandom_range(0, 99))};
      end
      7: begin
        pos  = $urandom_range(0, 11);
        bval = 8'($urandom);
        if (pos < 6) dc[47-8*pos -: 8] = bval;
        else tc[47-8*(pos-6) -: 8] = bval;
      end
      8: begin
        dl = 3'($urandom);
        tl = 3'($urandom);
      end
      9: begin
        dc = 48'({$urandom, $urandom});
        tc = 48'({$urandom, $urandom});
        dl = 3'($urandom);
        tl = 3'($urandom);
      end
      default: ;
    endcase
    return {2'b00, tl, tc, dl, dc};
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic offer(input logic [nde_pkg::InW-1:0] w, input bit typed,
                       input epoch_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(negedge clk_i); while (!s_axis_tready);
    epoch_q.push_back(typed ? want : epoch_of(w));
    n_items++;
    @(posedge clk_i);
  endtask

  task automatic pause(input int unsigned n);
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (epoch_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random ready pattern, two long hold-offs to back up the pipeline
  initial begin
    int unsigned cyc, n, mode;
    bit          held1, held2;
    cyc   = 0;
    held1 = 0;
    held2 = 0;
    wait (rst_ni);
    forever begin
      if ((!held1 && cyc >= 300) || (!held2 && cyc >= 3000)) begin
        if (!held1) held1 = 1;
        else held2 = 1;
        repeat (LongHold) begin
          @(posedge clk_i);
          m_axis_tready <= 1'b0;
          cyc++;
        end
      end
      mode = $urandom_range(0, 3);
      n    = $urandom_range(1, 24);
      repeat (n) begin
        @(posedge clk_i);
        case (mode)
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (n > 8) ? 1'b1 : 1'b0;
          default: m_axis_tready <= 1'b1;
        endcase
        cyc++;
      end
    end
  end

  // check results and watch for a hang; sampled mid-cycle
  always @(negedge clk_i) begin
    epoch_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok   = m_axis_tdata[0];
        got.secs = m_axis_tdata[30:1];
        if (epoch_q.size() == 0) begin
          report_mismatch("unexpected result, seconds", 32'(got.secs), 0);
        end else begin
          want = epoch_q.pop_front();
          if (got.ok !== want.ok) report_mismatch("valid_res", 32'(got.ok), 32'(want.ok));
          if (got.secs !== want.secs) begin
            report_mismatch("epoch_seconds", 32'(got.secs), 32'(want.secs));
          end
          if (want.ok) n_conv++;
          else n_rej++;
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no item moved for %0d cycles", IdleLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent, burst;
    // epoch start, top of range, hour 24 at the very end, years before 1970, sample dates
    add_row("700101", 6, "000000", 6, 1, 1'b1, 30'd0);
    add_row("991231", 6, "235959", 6, 1, 1'b1, 30'd946684799);
    add_row("991231", 6, "245959", 6, 1, 1'b1, 30'd946688399);
    add_row("690101", 6, "000000", 6, 1, 1'b1, 30'd0);
    add_row("691231", 6, "245959", 6, 0, 1'b0, 30'd0);
    add_row("000301", 6, "120000", 6, 0, 1'b0, 30'd0);
    add_row("720229", 6, "240000", 6, 0, 1'b0, 30'd0);
    add_row("720431", 6, "000000", 6, 0, 1'b0, 30'd0);
    add_row("840615", 6, "123456", 6, 0, 1'b0, 30'd0);
    // fields out of range
    add_row("700001", 6, "000000", 6, 1, 1'b0, 30'd0);
    add_row("701301", 6, "000000", 6, 1, 1'b0, 30'd0);
    add_row("700100", 6, "000000", 6, 1, 1'b0, 30'd0);
    add_row("700132", 6, "000000", 6, 1, 1'b0, 30'd0);
    add_row("700101", 6, "250000", 6, 1, 1'b0, 30'd0);
    add_row("700101", 6, "006000", 6, 1, 1'b0, 30'd0);
    add_row("700101", 6, "000060", 6, 1, 1'b0, 30'd0);
    add_row("999999", 6, "999999", 6, 1, 1'b0, 30'd0);
    // bad lengths and non-digit bytes
    add_row("700101", 5, "000000", 6, 1, 1'b0, 30'd0);
    add_row("700101", 6, "000000", 7, 1, 1'b0, 30'd0);
    add_row("700101", 0, "000000", 0, 1, 1'b0, 30'd0);
    add_row("70/101", 6, "000000", 6, 1, 1'b0, 30'd0);
    add_row("700101", 6, "00:000", 6, 1, 1'b0, 30'd0);
    add_row(48'hFFFF_FFFF_FFFF, 7, 48'hFFFF_FFFF_FFFF, 7, 1, 1'b0, 30'd0);
    add_row(48'h0, 6, 48'h0, 6, 1, 1'b0, 30'd0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tab[i]) begin
      offer({2'b00, stim_tab[i].tlen, stim_tab[i].tchars, stim_tab[i].dlen,
             stim_tab[i].dchars}, stim_tab[i].typed, stim_tab[i].want);
      pause($urandom_range(0, 2));
    end
    wait_drained();

    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        offer(rand_word(), 0, '0);
        sent++;
        // hold the input once mid-run until the pipeline is empty
        if (sent == NumRandom / 2) wait_drained();
      end
      pause($urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
    end

    wait_drained();
    repeat (DrainTail) @(posedge clk_i);
    $display("ran %0d items (directed extremes, range and format errors, random dates)",
             n_items);
    $display("results: %0d converted, %0d rejected, %0d mismatches", n_conv, n_rej,
             n_errors);
    if (n_errors == 0 && epoch_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
